/* hw/rtl/pidsq_pkg.sv */
// shared types and constants of the squared-error-window pid drive
// no dependencies; used by pidsq_smac and the top level
package pidsq_pkg;

	// fixed field widths
	localparam int GAIN_W    = 16;
	localparam int LAG_W     = 2;
	localparam int LIM_W     = 15;
	localparam int DRIVE_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// accumulator of the drive sum and its fraction bits (gains are q8.8)
	localparam int ACC_W     = 64;
	localparam int FRAC_BITS = 8;

	// windowed squared-error sum saturates at 2^47-1
	localparam int INTEG_W                 = 48;
	localparam logic [INTEG_W-1:0] INTEG_MAX = 48'h7FFF_FFFF_FFFF;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_LAG  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT  = 3'd4;

	// register reset values
	localparam logic [GAIN_W-1:0] GAIN_RST  = 16'd256;
	localparam logic [LAG_W-1:0]  LAG_RST   = 2'd1;
	localparam logic [LIM_W-1:0]  LIMIT_RST = 15'd1000;

	// control of the serial multiply-accumulate unit
	typedef struct packed {
		logic start;  // load operands and begin
		logic clear;  // zero the accumulator on start
		logic sgn;    // top multiplier bit carries negative weight
	} mac_ctl_t;

endpackage

/* hw/rtl/pidsq_smac.sv */
// bit-serial multiply-accumulate unit: one multiplier bit per cycle
// depends on pidsq_pkg (ACC_W, mac_ctl_t)
module pidsq_smac #(
	parameter int MR_W  = 16,
	parameter int LEN_W = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pidsq_pkg::mac_ctl_t         ctl,
	input  logic [pidsq_pkg::ACC_W-1:0] mc,
	input  logic [MR_W-1:0]             mr,
	input  logic [LEN_W-1:0]            len,
	output logic [pidsq_pkg::ACC_W-1:0] acc,
	output logic                        done
);

	logic                        busy_q;
	logic [LEN_W-1:0]            cnt_q;
	logic [LEN_W-1:0]            len_q;
	logic                        sgn_q;
	logic [pidsq_pkg::ACC_W-1:0] mc_q;
	logic [MR_W-1:0]             mr_q;
	logic [pidsq_pkg::ACC_W-1:0] acc_q;
	logic                        last;
	logic [pidsq_pkg::ACC_W-1:0] addend;
	logic [pidsq_pkg::ACC_W-1:0] acc_next;

	// current bit, subtracted when it is the sign bit of a signed multiplier
	always_comb begin
		last     = (cnt_q == len_q - LEN_W'(1));
		addend   = mr_q[0] ? mc_q : '0;
		acc_next = (sgn_q && last) ? acc_q - addend : acc_q + addend;
	end

	assign done = busy_q && last;
	assign acc  = acc_q;

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + LEN_W'(1);
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// operand shift registers and accumulator
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mc_q  <= mc;
			mr_q  <= mr;
			len_q <= len;
			sgn_q <= ctl.sgn;
			if (ctl.clear) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			acc_q <= acc_next;
			mc_q  <= {mc_q[pidsq_pkg::ACC_W-2:0], 1'b0};
			mr_q  <= {1'b0, mr_q[MR_W-1:1]};
		end
	end

endmodule

/* hw/rtl/pid_drive_with_squared_error_window.sv */
// pid drive stage with a windowed squared-error integral term
// depends on pidsq_pkg and pidsq_smac

// One result per item. The time from one input transaction to the next is set
// by a single bit-serial multiply-accumulate unit that forms the squared error
// and then the proportional, derivative and integral gain products. The window
// sum is kept as a running sum of stored squares, so INTEGRAL_WINDOW does not
// change the timing. A new item is taken while a finished result still waits
// in the output register.
// Configuration writes are always accepted and must only be made while idle.
module pid_drive_with_squared_error_window #(
	parameter int INTEGRAL_WINDOW = 5,
	parameter int SAMPLE_WIDTH    = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]      setpoint,
	input  logic signed [SAMPLE_WIDTH-1:0]      measurement,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pidsq_pkg::DRIVE_W-1:0] drive,
	output logic                                direction,
	output logic                                saturated,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pidsq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pidsq_pkg::CFG_DAT_W-1:0]     cfg_data
);

	localparam int SW     = SAMPLE_WIDTH;
	localparam int EW     = SW + 1;
	localparam int HD     = INTEGRAL_WINDOW - 1;
	localparam int SQ_W   = 2 * SW;
	localparam int SQS_W  = 2 * SW + $clog2(INTEGRAL_WINDOW);
	localparam int CMP_W  = (SQS_W > pidsq_pkg::INTEG_W) ? SQS_W : pidsq_pkg::INTEG_W;
	localparam int CNT_W  = $clog2(HD + 1);
	localparam int MR_W   = (SW > pidsq_pkg::GAIN_W) ? SW : pidsq_pkg::GAIN_W;
	localparam int LEN_W  = $clog2(MR_W + 1);
	localparam int LAG2_I = (HD >= 2) ? 1 : 0;
	localparam int DR_W   = pidsq_pkg::ACC_W - pidsq_pkg::FRAC_BITS;

	// sequencer states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DIFF  = 4'd1;
	localparam logic [3:0] ST_SQW   = 4'd2;
	localparam logic [3:0] ST_INTEG = 4'd3;
	localparam logic [3:0] ST_HIST  = 4'd4;
	localparam logic [3:0] ST_PW    = 4'd5;
	localparam logic [3:0] ST_LDD   = 4'd6;
	localparam logic [3:0] ST_DW    = 4'd7;
	localparam logic [3:0] ST_LDI   = 4'd8;
	localparam logic [3:0] ST_IW    = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// configuration registers
	logic [pidsq_pkg::GAIN_W-1:0] gp_q;
	logic [pidsq_pkg::GAIN_W-1:0] gi_q;
	logic [pidsq_pkg::GAIN_W-1:0] gd_q;
	logic [pidsq_pkg::LAG_W-1:0]  lag_q;
	logic [pidsq_pkg::LIM_W-1:0]  lim_q;

	// history and window state
	logic [EW-1:0]    eh_q [HD];
	logic [SQ_W-1:0]  sqh_q [HD];
	logic [SQS_W-1:0] ssum_q;
	logic [CNT_W-1:0] count_q;

	// per-item working registers
	logic [EW-1:0]                 e_q;
	logic [EW-1:0]                 deriv_q;
	logic [SQS_W-1:0]              integ_raw_q;
	logic [pidsq_pkg::INTEG_W-1:0] integ_q;

	// output register
	logic                                 ovalid_q;
	logic [pidsq_pkg::DRIVE_W-1:0]        drive_q;
	logic                                 dir_q;
	logic                                 sat_q;

	// serial mac interface
	pidsq_pkg::mac_ctl_t         mac_ctl;
	logic [pidsq_pkg::ACC_W-1:0] mac_mc;
	logic [MR_W-1:0]             mac_mr;
	logic [LEN_W-1:0]            mac_len;
	logic [pidsq_pkg::ACC_W-1:0] acc;
	logic                        mac_done;

	logic                          in_acc;
	logic                          out_load;
	logic [EW-1:0]                 e_new;
	logic [EW-1:0]                 e_neg;
	logic [SW-1:0]                 e_mag;
	logic [EW-1:0]                 e_old;
	logic [EW:0]                   diff;
	logic [CMP_W-1:0]              integ_ext;
	logic [pidsq_pkg::INTEG_W-1:0] integ_val;
	logic signed [DR_W-1:0]        dr;
	logic signed [DR_W-1:0]        lim_s;
	logic [pidsq_pkg::DRIVE_W-1:0] drive_val;
	logic                          sat_val;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = ovalid_q;
	assign drive     = drive_q;
	assign direction = dir_q;
	assign saturated = sat_q;
	assign out_load  = (state_q == ST_OUT) && (!ovalid_q || out_ready);

	// error, its magnitude and the derivative difference
	always_comb begin
		e_new = EW'(setpoint) - EW'(measurement);
		e_neg = -e_q;
		e_mag = e_q[EW-1] ? e_neg[SW-1:0] : e_q[SW-1:0];
		e_old = lag_q[1] ? eh_q[LAG2_I] : eh_q[0];
		diff  = (EW + 1)'($signed(e_q)) - (EW + 1)'($signed(e_old));
	end

	// window sum guard and the early-item zero
	always_comb begin
		integ_ext = CMP_W'(integ_raw_q);
		if (count_q != CNT_W'(HD)) begin
			integ_val = '0;
		end else if (integ_ext > CMP_W'(pidsq_pkg::INTEG_MAX)) begin
			integ_val = pidsq_pkg::INTEG_MAX;
		end else begin
			integ_val = pidsq_pkg::INTEG_W'(integ_ext);
		end
	end

	// scale down by the gain fraction and clamp
	always_comb begin
		dr    = $signed(acc[pidsq_pkg::ACC_W-1:pidsq_pkg::FRAC_BITS]);
		lim_s = $signed(DR_W'(lim_q));
		if (dr > lim_s) begin
			drive_val = lim_s[pidsq_pkg::DRIVE_W-1:0];
			sat_val   = 1'b1;
		end else if (dr < -lim_s) begin
			drive_val = pidsq_pkg::DRIVE_W'(-lim_s);
			sat_val   = 1'b1;
		end else begin
			drive_val = dr[pidsq_pkg::DRIVE_W-1:0];
			sat_val   = 1'b0;
		end
	end

	// next state and mac operand selection
	always_comb begin
		state_d = state_q;
		mac_ctl = '0;
		mac_mc  = '0;
		mac_mr  = '0;
		mac_len = LEN_W'(pidsq_pkg::GAIN_W);
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: begin
				mac_ctl = '{start: 1'b1, clear: 1'b1, sgn: 1'b0};
				mac_mc  = pidsq_pkg::ACC_W'(e_mag);
				mac_mr  = MR_W'(e_mag);
				mac_len = LEN_W'(SW);
				state_d = ST_SQW;
			end
			ST_SQW: begin
				if (mac_done) begin
					state_d = ST_INTEG;
				end
			end
			ST_INTEG: begin
				state_d = ST_HIST;
			end
			ST_HIST: begin
				mac_ctl = '{start: 1'b1, clear: 1'b1, sgn: 1'b1};
				mac_mc  = pidsq_pkg::ACC_W'($signed(e_q));
				mac_mr  = MR_W'(gp_q);
				state_d = ST_PW;
			end
			ST_PW: begin
				if (mac_done) begin
					state_d = ST_LDD;
				end
			end
			ST_LDD: begin
				mac_ctl = '{start: 1'b1, clear: 1'b0, sgn: 1'b1};
				mac_mc  = pidsq_pkg::ACC_W'($signed(deriv_q));
				mac_mr  = MR_W'(gd_q);
				state_d = ST_DW;
			end
			ST_DW: begin
				if (mac_done) begin
					state_d = ST_LDI;
				end
			end
			ST_LDI: begin
				mac_ctl = '{start: 1'b1, clear: 1'b0, sgn: 1'b1};
				mac_mc  = pidsq_pkg::ACC_W'(integ_q);
				mac_mr  = MR_W'(gi_q);
				state_d = ST_IW;
			end
			ST_IW: begin
				if (mac_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	pidsq_smac #(
		.MR_W  (MR_W),
		.LEN_W (LEN_W)
	) u_smac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.mc     (mac_mc),
		.mr     (mac_mr),
		.len    (mac_len),
		.acc    (acc),
		.done   (mac_done)
	);

	// state register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q  <= pidsq_pkg::GAIN_RST;
			gi_q  <= pidsq_pkg::GAIN_RST;
			gd_q  <= pidsq_pkg::GAIN_RST;
			lag_q <= pidsq_pkg::LAG_RST;
			lim_q <= pidsq_pkg::LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pidsq_pkg::REG_GAIN_PROP:  gp_q  <= cfg_data;
				pidsq_pkg::REG_GAIN_INTEG: gi_q  <= cfg_data;
				pidsq_pkg::REG_GAIN_DERIV: gd_q  <= cfg_data;
				pidsq_pkg::REG_DERIV_LAG:  lag_q <= cfg_data[pidsq_pkg::LAG_W-1:0];
				pidsq_pkg::REG_OUT_LIMIT:  lim_q <= cfg_data[pidsq_pkg::LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// error history, stored squares, running window sum and item count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HD; i++) begin
				eh_q[i]  <= '0;
				sqh_q[i] <= '0;
			end
			ssum_q  <= '0;
			count_q <= '0;
		end else if (state_q == ST_HIST) begin
			eh_q[0]  <= e_q;
			sqh_q[0] <= acc[SQ_W-1:0];
			for (int i = 1; i < HD; i++) begin
				eh_q[i]  <= eh_q[i-1];
				sqh_q[i] <= sqh_q[i-1];
			end
			ssum_q <= integ_raw_q - SQS_W'(sqh_q[HD-1]);
			if (count_q != CNT_W'(HD)) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			e_q <= e_new;
		end
		if (state_q == ST_DIFF) begin
			deriv_q <= diff[EW:1];
		end
		if (state_q == ST_INTEG) begin
			integ_raw_q <= ssum_q + SQS_W'(acc[SQ_W-1:0]);
		end
		if (state_q == ST_HIST) begin
			integ_q <= integ_val;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			drive_q <= drive_val;
			dir_q   <= !e_q[EW-1];
			sat_q   <= sat_val;
		end
	end

endmodule

/* tb/pid_drive_with_squared_error_window_test.sv */
`timescale 1ns / 100ps
// self-checking testbench of the squared-error-window pid drive stage
// depends on pidsq_pkg and pid_drive_with_squared_error_window

module pid_drive_with_squared_error_window_test;

	localparam int WINDOW            = 5;
	localparam int SAMPLE_W          = 16;
	localparam int HIST_DEPTH        = WINDOW - 1;
	localparam int STALL_LIMIT       = 4000;
	localparam int SETTLE_CYCLES     = 80;
	localparam int RANDOM_ITEMS      = 2000;
	localparam int ITEMS_PER_SETTING = 100;

	typedef struct packed {
		logic [pidsq_pkg::DRIVE_W-1:0] drive;
		logic                          direction;
		logic                          saturated;
	} drive_rec_t;

	logic                            clk         = 1'b0;
	logic                            arst_n      = 1'b0;
	logic                            in_valid    = 1'b0;
	logic                            in_ready;
	logic signed [SAMPLE_W-1:0]      setpoint    = '0;
	logic signed [SAMPLE_W-1:0]      measurement = '0;
	logic                            out_valid;
	logic                            out_ready   = 1'b0;
	logic [pidsq_pkg::DRIVE_W-1:0]   drive;
	logic                            direction;
	logic                            saturated;
	logic                            cfg_valid   = 1'b0;
	logic                            cfg_ready;
	logic [pidsq_pkg::CFG_IDX_W-1:0] cfg_index   = pidsq_pkg::REG_GAIN_PROP;
	logic [pidsq_pkg::CFG_DAT_W-1:0] cfg_data    = '0;

	// idle percentages of the two channels
	int src_gap_pct   = 0;
	int snk_stall_pct = 0;

	int err_count    = 0;
	int quiet_cycles = 0;

	// drive results still owed by the block, oldest first
	drive_rec_t pending_drives[$];

	// shadow of the register file and the error history
	longint                      prop_gain     = longint'($signed(pidsq_pkg::GAIN_RST));
	longint                      integ_gain    = longint'($signed(pidsq_pkg::GAIN_RST));
	longint                      deriv_gain    = longint'($signed(pidsq_pkg::GAIN_RST));
	logic [pidsq_pkg::LAG_W-1:0] lag_setting   = pidsq_pkg::LAG_RST;
	longint                      limit_setting = longint'(pidsq_pkg::LIMIT_RST);
	longint                      err_hist[HIST_DEPTH] = '{default: 0};
	int                          seen_items    = 0;

	pid_drive_with_squared_error_window #(
		.INTEGRAL_WINDOW(WINDOW),
		.SAMPLE_WIDTH   (SAMPLE_W)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.setpoint   (setpoint),
		.measurement(measurement),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.drive      (drive),
		.direction  (direction),
		.saturated  (saturated),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// expected drive of one sample, advances the shadow history
	function automatic drive_rec_t predict_drive(input logic signed [SAMPLE_W-1:0] sp,
			input logic signed [SAMPLE_W-1:0] ms);
		longint     err, deriv, integ, acc, drv;
		int         lag, i;
		drive_rec_t res;
		err = longint'(sp) - longint'(ms);
		// lag codes outside one and two fall back to the nearest legal lag
		if (lag_setting == 2'd0)
			lag = 1;
		else if (lag_setting == 2'd3)
			lag = 2;
		else
			lag = int'(lag_setting);
		deriv = (err - err_hist[lag - 1]) >>> 1;
		// window sum of squares, zero until the history is filled
		integ = 0;
		if (seen_items >= HIST_DEPTH) begin
			integ = err * err;
			for (i = 0; i < HIST_DEPTH; i++) begin
				integ += err_hist[i] * err_hist[i];
				if (integ > longint'(pidsq_pkg::INTEG_MAX))
					integ = longint'(pidsq_pkg::INTEG_MAX);
			end
		end
		acc = prop_gain * err + integ_gain * integ + deriv_gain * deriv;
		drv = acc >>> pidsq_pkg::FRAC_BITS;
		// symmetric clamp
		res.saturated = 1'b0;
		if (drv > limit_setting) begin
			drv = limit_setting;
			res.saturated = 1'b1;
		end
		if (drv < -limit_setting) begin
			drv = -limit_setting;
			res.saturated = 1'b1;
		end
		res.drive     = pidsq_pkg::DRIVE_W'(drv);
		res.direction = (err >= 0);
		for (i = HIST_DEPTH - 1; i > 0; i--)
			err_hist[i] = err_hist[i - 1];
		err_hist[0] = err;
		if (seen_items < HIST_DEPTH)
			seen_items++;
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		err_count++;
		$display("%0t ns mismatch: %s", $time, what);
	endtask

	// receiver stalls at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		drive_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_drives.size() == 0) begin
				report_mismatch($sformatf("unexpected result, drive %0d", $signed(drive)));
			end else begin
				want = pending_drives.pop_front();
				if (drive !== want.drive)
					report_mismatch($sformatf("drive %0d, want %0d",
						$signed(drive), $signed(want.drive)));
				if (direction !== want.direction)
					report_mismatch($sformatf("direction %b, want %b",
						direction, want.direction));
				if (saturated !== want.saturated)
					report_mismatch($sformatf("saturated %b, want %b (drive %0d)",
						saturated, want.saturated, $signed(want.drive)));
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d cycles without a transaction", STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offer one sample and wait for its transaction
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] sp,
			input logic signed [SAMPLE_W-1:0] ms);
		int gap;
		// gaps long enough to land anywhere in the block's computation
		if ($urandom_range(99) < src_gap_pct) begin
			gap = $urandom_range(90, 1);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		setpoint    <= sp;
		measurement <= ms;
		in_valid    <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_drives.push_back(predict_drive(sp, ms));
	endtask

	// stop offering samples and wait until every result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_drives.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pidsq_pkg::CFG_IDX_W-1:0] idx,
			input logic [pidsq_pkg::CFG_DAT_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			pidsq_pkg::REG_GAIN_PROP:  prop_gain     = longint'($signed(data));
			pidsq_pkg::REG_GAIN_INTEG: integ_gain    = longint'($signed(data));
			pidsq_pkg::REG_GAIN_DERIV: deriv_gain    = longint'($signed(data));
			pidsq_pkg::REG_DERIV_LAG:  lag_setting   = data[pidsq_pkg::LAG_W-1:0];
			pidsq_pkg::REG_OUT_LIMIT:  limit_setting = longint'(data[pidsq_pkg::LIM_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [pidsq_pkg::GAIN_W-1:0] kp,
			input logic [pidsq_pkg::GAIN_W-1:0] ki,
			input logic [pidsq_pkg::GAIN_W-1:0] kd, input logic [pidsq_pkg::LAG_W-1:0] lag,
			input logic [pidsq_pkg::LIM_W-1:0] lim);
		write_reg(pidsq_pkg::REG_GAIN_PROP, kp);
		write_reg(pidsq_pkg::REG_GAIN_INTEG, ki);
		write_reg(pidsq_pkg::REG_GAIN_DERIV, kd);
		write_reg(pidsq_pkg::REG_DERIV_LAG, pidsq_pkg::CFG_DAT_W'(lag));
		write_reg(pidsq_pkg::REG_OUT_LIMIT, pidsq_pkg::CFG_DAT_W'(lim));
	endtask

	function automatic logic [pidsq_pkg::GAIN_W-1:0] pick_gain();
		case ($urandom_range(4))
			0: return pidsq_pkg::GAIN_W'($urandom);
			1: return pidsq_pkg::GAIN_W'($urandom_range(1024) - 512);
			2: return '0;
			3: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
			default: return pidsq_pkg::GAIN_RST;
		endcase
	endfunction

	function automatic logic [pidsq_pkg::LIM_W-1:0] pick_limit();
		case ($urandom_range(3))
			0: return '0;
			1: return 15'h7FFF;
			2: return pidsq_pkg::LIM_W'($urandom);
			default: return pidsq_pkg::LIM_W'($urandom_range(2000));
		endcase
	endfunction

	// history fill from reset, integral held at zero for the first items
	task automatic test_early_samples();
		send_sample(16'sd0, 16'sd0);
		send_sample(16'sd3, 16'sd1);
		send_sample(-16'sd5, 16'sd2);
		send_sample(16'sd1, 16'sd1);
		send_sample(16'sd10, 16'sd4);
		send_sample(16'sh7FFF, 16'sh8000);
		send_sample(16'sh8000, 16'sh7FFF);
		send_sample(16'sd0, 16'sd0);
		drain_results();
	endtask

	// derivative alone, every lag code including the out-of-range ones
	task automatic test_derivative_lag();
		int code;
		for (code = 0; code < 4; code++) begin
			load_settings(16'd0, 16'd0, pidsq_pkg::GAIN_RST, pidsq_pkg::LAG_W'(code),
				15'h7FFF);
			send_sample(16'sd40, -16'sd3);
			send_sample(-16'sd17, 16'sd22);
			drain_results();
		end
	endtask

	// zero limit with zero and nonzero sums, then the widest limit
	task automatic test_output_limit();
		load_settings(16'd0, 16'd0, 16'd0, pidsq_pkg::LAG_RST, 15'd0);
		send_sample(16'sd7, -16'sd7);
		drain_results();
		load_settings(pidsq_pkg::GAIN_RST, pidsq_pkg::GAIN_RST, pidsq_pkg::GAIN_RST,
			pidsq_pkg::LAG_RST, 15'd0);
		send_sample(16'sd5, 16'sd0);
		send_sample(-16'sd5, 16'sd0);
		drain_results();
		load_settings(pidsq_pkg::GAIN_RST, pidsq_pkg::GAIN_RST, pidsq_pkg::GAIN_RST,
			pidsq_pkg::LAG_RST, 15'h7FFF);
		send_sample(16'sh7FFF, 16'sh8000);
		send_sample(16'sh8000, 16'sh7FFF);
		drain_results();
	endtask

	// most negative and most positive gains
	task automatic test_gain_extremes();
		load_settings(16'h8000, 16'h7FFF, 16'h8000, 2'd2, 15'h7FFF);
		send_sample(16'sd100, -16'sd3);
		send_sample(-16'sd20, 16'sd7);
		drain_results();
		load_settings(16'h7FFF, 16'h0000, 16'h7FFF, 2'd1, pidsq_pkg::LIMIT_RST);
		send_sample(16'sh8000, 16'sh7FFF);
		drain_results();
	endtask

	// random samples under changing settings and channel idling
	task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_items);
		int                         k;
		logic signed [SAMPLE_W-1:0] sp, ms;
		src_gap_pct   = src_pct;
		snk_stall_pct = snk_pct;
		for (k = 0; k < n_items; k++) begin
			if (k % ITEMS_PER_SETTING == 0) begin
				drain_results();
				load_settings(pick_gain(), pick_gain(), pick_gain(),
					pidsq_pkg::LAG_W'($urandom_range(3)), pick_limit());
			end
			case ($urandom_range(9))
				0, 1, 2: begin
					sp = SAMPLE_W'($urandom);
					ms = SAMPLE_W'($urandom);
				end
				// small error around a random operating point
				3, 4, 5: begin
					sp = SAMPLE_W'($urandom);
					ms = sp + SAMPLE_W'($urandom_range(64)) - SAMPLE_W'(32);
				end
				// small setpoint and measurement values around zero
				6, 7, 8: begin
					sp = SAMPLE_W'($urandom_range(64)) - SAMPLE_W'(32);
					ms = SAMPLE_W'($urandom_range(64)) - SAMPLE_W'(32);
				end
				default: begin
					sp = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
					ms = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
				end
			endcase
			send_sample(sp, ms);
		end
		drain_results();
	endtask

	// test sequence
	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_gap_pct   = 24;
		snk_stall_pct = 84;
		test_early_samples();
		test_derivative_lag();
		test_output_limit();
		test_gain_extremes();
		test_random_traffic(24, 84, RANDOM_ITEMS / 3);
		test_random_traffic(84, 24, RANDOM_ITEMS / 3);
		test_random_traffic(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0 && pending_drives.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/pidsq_pkg.sv
hw/rtl/pidsq_smac.sv
hw/rtl/pid_drive_with_squared_error_window.sv
tb/pid_drive_with_squared_error_window_test.sv
